[rtl/rmf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmf_pkg
// Shared constants, types and register codes of the rgb median window filter.
// ----------------------------------------------------------------------------
package rmf_pkg;

  localparam int RADIUS     = 1;
  localparam int MAX_WIDTH  = 1024;
  localparam int WIN        = 2 * RADIUS + 1;
  localparam int AREA       = WIN * WIN;
  localparam int MEDIAN_POS = (AREA - 1) / 2;

  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int FW_W       = 11;
  localparam int FH_W       = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int LAG_W = $clog2(RADIUS * MAX_WIDTH + RADIUS + 1);
  localparam int OFF_W = $clog2(RADIUS + 1);
  localparam int SEL_W = $clog2(WIN);
  localparam int CNT_W = $clog2(AREA + 1);
  localparam int ENT_W = 2 * RADIUS * PIX_W;

  localparam logic [FW_W-1:0] RESET_WIDTH  = FW_W'(640);
  localparam logic [FH_W-1:0] RESET_HEIGHT = FH_W'(480);

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [CH_W-1:0]  chan_t;

  // per-item control: result flags and distances to the frame edges
  typedef struct packed {
    logic             emit;
    logic             last;
    logic [OFF_W-1:0] up;
    logic [OFF_W-1:0] dn;
    logic [OFF_W-1:0] lf;
    logic [OFF_W-1:0] rt;
  } ctl_t;

endpackage

[rtl/rmf_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmf_ram
// Generic single write port RAM with a registered, read-first read port.
// ----------------------------------------------------------------------------
module rmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/rmf_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmf_ctrl
// Frame size registers, input and result position counters, edge distances.
// ----------------------------------------------------------------------------
module rmf_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             accept,
  input  logic                             mode,
  input  logic                             cfg_we,
  input  logic [rmf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rmf_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                             shift,
  output rmf_pkg::ctl_t                    ctl,
  output logic [rmf_pkg::COL_W-1:0]        in_col
);

  logic [rmf_pkg::FW_W-1:0]  frame_width;
  logic [rmf_pkg::FH_W-1:0]  frame_height;
  logic [rmf_pkg::FH_W-1:0]  in_row;
  logic                      received;
  logic [rmf_pkg::LAG_W-1:0] pre;
  logic [rmf_pkg::COL_W-1:0] out_col;
  logic [rmf_pkg::FH_W-1:0]  out_row;

  logic [rmf_pkg::COL_W:0]   eff_w;
  logic [rmf_pkg::FH_W-1:0]  eff_h;
  logic [rmf_pkg::LAG_W-1:0] lag;
  logic                      col_wrap;
  logic                      row_done;
  logic                      out_col_end;
  logic                      out_row_end;
  logic [rmf_pkg::COL_W:0]   col_rem;
  logic [rmf_pkg::FH_W-1:0]  row_rem;

  always_comb begin
    if (frame_width == '0) begin
      eff_w = (rmf_pkg::COL_W+1)'(1);
    end else if (32'(frame_width) > 32'(rmf_pkg::MAX_WIDTH)) begin
      eff_w = (rmf_pkg::COL_W+1)'(rmf_pkg::MAX_WIDTH);
    end else begin
      eff_w = (rmf_pkg::COL_W+1)'(frame_width);
    end
    eff_h = (frame_height == '0) ? rmf_pkg::FH_W'(1) : frame_height;
    lag   = rmf_pkg::LAG_W'(rmf_pkg::RADIUS) * rmf_pkg::LAG_W'(eff_w)
          + rmf_pkg::LAG_W'(rmf_pkg::RADIUS);

    shift       = !(mode && !received);
    col_wrap    = ({1'b0, in_col} + 1'b1) == eff_w;
    row_done    = ({1'b0, in_row} + 1'b1) == {1'b0, eff_h};
    out_col_end = ({1'b0, out_col} + 1'b1) == eff_w;
    out_row_end = ({1'b0, out_row} + 1'b1) == {1'b0, eff_h};
    col_rem     = eff_w - 1'b1 - {1'b0, out_col};
    row_rem     = eff_h - 1'b1 - out_row;

    ctl.emit = (pre == lag);
    ctl.last = ctl.emit && out_col_end && out_row_end;
    ctl.up   = (out_row < rmf_pkg::FH_W'(rmf_pkg::RADIUS)) ?
               rmf_pkg::OFF_W'(out_row) : rmf_pkg::OFF_W'(rmf_pkg::RADIUS);
    ctl.dn   = (row_rem < rmf_pkg::FH_W'(rmf_pkg::RADIUS)) ?
               rmf_pkg::OFF_W'(row_rem) : rmf_pkg::OFF_W'(rmf_pkg::RADIUS);
    ctl.lf   = (out_col < rmf_pkg::COL_W'(rmf_pkg::RADIUS)) ?
               rmf_pkg::OFF_W'(out_col) : rmf_pkg::OFF_W'(rmf_pkg::RADIUS);
    ctl.rt   = (col_rem < (rmf_pkg::COL_W+1)'(rmf_pkg::RADIUS)) ?
               rmf_pkg::OFF_W'(col_rem) : rmf_pkg::OFF_W'(rmf_pkg::RADIUS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= rmf_pkg::RESET_WIDTH;
      frame_height <= rmf_pkg::RESET_HEIGHT;
      in_col       <= '0;
      in_row       <= '0;
      received     <= 1'b0;
      pre          <= '0;
      out_col      <= '0;
      out_row      <= '0;
    end else if (cfg_we) begin
      if (cfg_index == rmf_pkg::CFG_FRAME_WIDTH ||
          cfg_index == rmf_pkg::CFG_FRAME_HEIGHT) begin
        if (cfg_index == rmf_pkg::CFG_FRAME_WIDTH) begin
          frame_width <= cfg_data[rmf_pkg::FW_W-1:0];
        end else begin
          frame_height <= cfg_data[rmf_pkg::FH_W-1:0];
        end
        in_col   <= '0;
        in_row   <= '0;
        received <= 1'b0;
        pre      <= '0;
        out_col  <= '0;
        out_row  <= '0;
      end
    end else if (accept && shift) begin
      if (ctl.last) begin
        // final result of the frame restarts every position
        in_col   <= '0;
        in_row   <= '0;
        received <= 1'b0;
        pre      <= '0;
        out_col  <= '0;
        out_row  <= '0;
      end else begin
        in_col <= col_wrap ? '0 : in_col + 1'b1;
        if (!received && col_wrap) begin
          in_row <= in_row + 1'b1;
          if (row_done) begin
            received <= 1'b1;
          end
        end
        if (!ctl.emit) begin
          pre <= pre + 1'b1;
        end else begin
          out_col <= out_col_end ? '0 : out_col + 1'b1;
          if (out_col_end) begin
            out_row <= out_row + 1'b1;
          end
        end
      end
    end
  end

endmodule

[rtl/rmf_window.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmf_window
// Line buffers, window shift registers and edge clamped window selection.
// ----------------------------------------------------------------------------
module rmf_window (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load1,
  input  logic                       adv1,
  input  logic                       adv2,
  input  rmf_pkg::pix_t              pix_in,
  input  logic [rmf_pkg::COL_W-1:0]  col_in,
  input  rmf_pkg::ctl_t              ctl_in,
  output logic                       s1_emit,
  output logic                       s3_last,
  output rmf_pkg::pix_t              win_sel [rmf_pkg::AREA]
);

  rmf_pkg::pix_t             pix1;
  logic [rmf_pkg::COL_W-1:0] col1;
  rmf_pkg::ctl_t             ctl1;
  logic                      byp1;
  logic [rmf_pkg::ENT_W-1:0] byp_data1;
  logic                      wr_pend;
  logic [rmf_pkg::ENT_W-1:0] ram_q;
  logic [rmf_pkg::ENT_W-1:0] ent;
  logic [rmf_pkg::ENT_W+rmf_pkg::PIX_W-1:0] ent_shift;
  logic [rmf_pkg::ENT_W-1:0] wr_data;
  rmf_pkg::pix_t             col_pix [rmf_pkg::WIN];

  rmf_pkg::pix_t             win [rmf_pkg::WIN][rmf_pkg::WIN];
  rmf_pkg::ctl_t             ctl2;
  logic [rmf_pkg::SEL_W-1:0] jsel [rmf_pkg::WIN];
  logic [rmf_pkg::SEL_W-1:0] ksel [rmf_pkg::WIN];
  rmf_pkg::pix_t             sel_d [rmf_pkg::AREA];

  function automatic logic [rmf_pkg::SEL_W-1:0] tap(
    input int a, input logic [rmf_pkg::OFF_W-1:0] lo, input logic [rmf_pkg::OFF_W-1:0] hi
  );
    int d;
    d = a - rmf_pkg::RADIUS;
    if (d < -int'(lo)) d = -int'(lo);
    if (d > int'(hi)) d = int'(hi);
    return rmf_pkg::SEL_W'(rmf_pkg::RADIUS - d);
  endfunction

  // one entry per column holds the pixels one to 2R rows back
  rmf_ram #(
    .WIDTH (rmf_pkg::ENT_W),
    .DEPTH (rmf_pkg::MAX_WIDTH)
  ) u_line (
    .clk     (clk),
    .wr_en   (wr_pend),
    .wr_addr (col1),
    .wr_data (wr_data),
    .rd_en   (load1),
    .rd_addr (col_in),
    .rd_data (ram_q)
  );

  always_comb begin
    ent       = byp1 ? byp_data1 : ram_q;
    ent_shift = {ent, pix1};
    wr_data   = ent_shift[rmf_pkg::ENT_W-1:0];
    col_pix[0] = pix1;
    for (int j = 1; j < rmf_pkg::WIN; j++) begin
      col_pix[j] = ent[(j-1)*rmf_pkg::PIX_W +: rmf_pkg::PIX_W];
    end
    s1_emit = ctl1.emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pend <= 1'b0;
    end else begin
      wr_pend <= load1;
    end
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      pix1      <= pix_in;
      col1      <= col_in;
      ctl1      <= ctl_in;
      // write of the previous item still in flight to the same column
      byp1      <= wr_pend && (col1 == col_in);
      byp_data1 <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      ctl2 <= ctl1;
      for (int j = 0; j < rmf_pkg::WIN; j++) begin
        win[j][0] <= col_pix[j];
        for (int k = 1; k < rmf_pkg::WIN; k++) begin
          win[j][k] <= win[j][k-1];
        end
      end
    end
  end

  always_comb begin
    for (int a = 0; a < rmf_pkg::WIN; a++) begin
      jsel[a] = tap(a, ctl2.up, ctl2.dn);
      ksel[a] = tap(a, ctl2.lf, ctl2.rt);
    end
    for (int a = 0; a < rmf_pkg::WIN; a++) begin
      for (int b = 0; b < rmf_pkg::WIN; b++) begin
        sel_d[a*rmf_pkg::WIN+b] = '0;
        for (int j = 0; j < rmf_pkg::WIN; j++) begin
          for (int k = 0; k < rmf_pkg::WIN; k++) begin
            if (jsel[a] == rmf_pkg::SEL_W'(j) && ksel[b] == rmf_pkg::SEL_W'(k)) begin
              sel_d[a*rmf_pkg::WIN+b] = sel_d[a*rmf_pkg::WIN+b] | win[j][k];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s3_last <= ctl2.last;
      for (int i = 0; i < rmf_pkg::AREA; i++) begin
        win_sel[i] <= sel_d[i];
      end
    end
  end

endmodule

[rtl/rmf_median.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmf_median
// Rank based median of one colour channel over the selected window.
// ----------------------------------------------------------------------------
module rmf_median (
  input  logic           clk,
  input  logic           adv3,
  input  logic           adv4,
  input  rmf_pkg::chan_t vals [rmf_pkg::AREA],
  output rmf_pkg::chan_t med
);

  rmf_pkg::chan_t            vals4 [rmf_pkg::AREA];
  logic [rmf_pkg::AREA-1:0]  hit4;
  logic [rmf_pkg::AREA-1:0]  hit_d;
  logic [rmf_pkg::CNT_W-1:0] n_lt [rmf_pkg::AREA];
  logic [rmf_pkg::CNT_W-1:0] n_eq [rmf_pkg::AREA];
  rmf_pkg::chan_t            med_d;

  // an element is the median when its rank range covers the middle position
  always_comb begin
    for (int i = 0; i < rmf_pkg::AREA; i++) begin
      n_lt[i] = '0;
      n_eq[i] = '0;
      for (int j = 0; j < rmf_pkg::AREA; j++) begin
        n_lt[i] = n_lt[i] + rmf_pkg::CNT_W'(vals[j] < vals[i]);
        n_eq[i] = n_eq[i] + rmf_pkg::CNT_W'(vals[j] == vals[i]);
      end
      hit_d[i] = (n_lt[i] <= rmf_pkg::CNT_W'(rmf_pkg::MEDIAN_POS)) &&
                 ((n_lt[i] + n_eq[i]) > rmf_pkg::CNT_W'(rmf_pkg::MEDIAN_POS));
    end
  end

  // all hits carry the same value, so or-ing them is enough
  always_comb begin
    med_d = '0;
    for (int i = 0; i < rmf_pkg::AREA; i++) begin
      if (hit4[i]) begin
        med_d = med_d | vals4[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      hit4 <= hit_d;
      for (int i = 0; i < rmf_pkg::AREA; i++) begin
        vals4[i] <= vals[i];
      end
    end
    if (adv4) begin
      med <= med_d;
    end
  end

endmodule

[rtl/rgb_median_window_filter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_median_window_filter_core
// Streaming per-channel median over a (2R+1)x(2R+1) edge clamped window.
// ----------------------------------------------------------------------------
// result path: item n+R*W+R yields pixel n via the input, window, select, rank and output registers
// throughput: one item per cycle while the output is not held, set by the single line buffer port pair
// input stalls only when every stage is full behind a held output register
// reset: frame size returns to 640x480, all positions clear, pipeline empties
// line buffer contents are not cleared; reads of stale rows are clamped away
module rgb_median_window_filter_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [23:0]                    s_tdata,   // in_red, in_green, in_blue
  input  logic                           s_tuser,   // mode
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [23:0]                    m_tdata,   // out_red, out_green, out_blue
  output logic                           m_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rmf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rmf_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic                      accept;
  logic                      shift;
  logic                      load1;
  rmf_pkg::ctl_t             ctl;
  logic [rmf_pkg::COL_W-1:0] in_col;
  logic                      v1, v2, v3, v4;
  logic                      adv1, adv2, adv3, adv4;
  logic                      s1_emit;
  logic                      s3_last;
  logic                      last4;
  rmf_pkg::pix_t             win_sel [rmf_pkg::AREA];
  rmf_pkg::chan_t            red_w   [rmf_pkg::AREA];
  rmf_pkg::chan_t            green_w [rmf_pkg::AREA];
  rmf_pkg::chan_t            blue_w  [rmf_pkg::AREA];
  rmf_pkg::chan_t            med_r, med_g, med_b;

  always_comb begin
    adv4      = v4 && (!m_tvalid || m_tready);
    adv3      = v3 && (!v4 || adv4);
    adv2      = v2 && (!v3 || adv3);
    adv1      = v1 && (!v2 || adv2);
    s_tready  = !v1 || adv1;
    cfg_ready = 1'b1;
    accept    = s_tvalid && s_tready;
    load1     = accept && shift;
    m_tdata   = {med_b, med_g, med_r};
    for (int i = 0; i < rmf_pkg::AREA; i++) begin
      red_w[i]   = win_sel[i][7:0];
      green_w[i] = win_sel[i][15:8];
      blue_w[i]  = win_sel[i][23:16];
    end
  end

  rmf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .mode      (s_tuser),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .shift     (shift),
    .ctl       (ctl),
    .in_col    (in_col)
  );

  rmf_window u_window (
    .clk     (clk),
    .rst     (rst),
    .load1   (load1),
    .adv1    (adv1),
    .adv2    (adv2),
    .pix_in  (s_tdata),
    .col_in  (in_col),
    .ctl_in  (ctl),
    .s1_emit (s1_emit),
    .s3_last (s3_last),
    .win_sel (win_sel)
  );

  rmf_median u_med_r (.clk(clk), .adv3(adv3), .adv4(adv4), .vals(red_w),   .med(med_r));
  rmf_median u_med_g (.clk(clk), .adv3(adv3), .adv4(adv4), .vals(green_w), .med(med_g));
  rmf_median u_med_b (.clk(clk), .adv3(adv3), .adv4(adv4), .vals(blue_w),  .med(med_b));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      v4       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      v1 <= load1 ? 1'b1 : (adv1 ? 1'b0 : v1);
      // items that give no result only move the window
      v2 <= adv1 ? s1_emit : (adv2 ? 1'b0 : v2);
      v3 <= adv2 ? 1'b1 : (adv3 ? 1'b0 : v3);
      v4 <= adv3 ? 1'b1 : (adv4 ? 1'b0 : v4);
      m_tvalid <= adv4 ? 1'b1 : ((m_tvalid && m_tready) ? 1'b0 : m_tvalid);
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      last4 <= s3_last;
    end
    if (adv4) begin
      m_tlast <= last4;
    end
  end

endmodule

[rtl/rmf_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmf_checker
// Port level checks of the median filter core, bound to the top level.
// ----------------------------------------------------------------------------
module rmf_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tlast,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // a held result keeps its request
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output request dropped or changed while stalled");

  // with the output register empty the whole pipeline drains, so input is open
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output register");

  a_cfg_open: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration request not taken");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result request after reset");

endmodule

bind rgb_median_window_filter_core rmf_checker u_rmf_checker (.*);

[dv/median_stream_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_stream_checker
// Watches the pixel, result and register channels of the median filter, keeps
// its own line store and frame counters, predicts each window median and
// compares every result with the oldest predicted pixel.
// ----------------------------------------------------------------------------
module median_stream_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [23:0]                    s_tdata,
  input  logic                           s_tuser,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [23:0]                    m_tdata,
  input  logic                           m_tlast,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [rmf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rmf_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             pending,
  output int                             errors
);

  localparam int DEPTH = rmf_pkg::WIN * rmf_pkg::MAX_WIDTH;

  typedef struct {
    rmf_pkg::chan_t red;
    rmf_pkg::chan_t green;
    rmf_pkg::chan_t blue;
    logic           last;
  } median_pix_t;

  logic [rmf_pkg::FW_W-1:0] width_reg;
  logic [rmf_pkg::FH_W-1:0] height_reg;
  rmf_pkg::pix_t            line_store [DEPTH];
  int unsigned              in_col, in_row, out_col, out_row;
  bit                       frame_in;
  median_pix_t              medians_due [$];

  assign pending = medians_due.size();

  function automatic rmf_pkg::chan_t median9(input rmf_pkg::chan_t v [rmf_pkg::AREA]);
    rmf_pkg::chan_t key;
    int             j;
    for (int i = 1; i < rmf_pkg::AREA; i++) begin
      key = v[i];
      j = i - 1;
      while (j >= 0 && v[j] > key) begin
        v[j+1] = v[j];
        j--;
      end
      v[j+1] = key;
    end
    return v[rmf_pkg::MEDIAN_POS];
  endfunction

  function automatic int clampi(input int v, input int hi);
    return v < 0 ? 0 : (v > hi ? hi : v);
  endfunction

  task automatic restart();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
    frame_in = 0;
  endtask

  task automatic take_item(input logic drain, input rmf_pkg::pix_t px);
    int unsigned    w, h, total, lag, pos, rr, cc;
    rmf_pkg::chan_t rv [rmf_pkg::AREA];
    rmf_pkg::chan_t gv [rmf_pkg::AREA];
    rmf_pkg::chan_t bv [rmf_pkg::AREA];
    rmf_pkg::pix_t  p;
    median_pix_t    res;
    int             k;
    w = width_reg == 0 ? 1 :
        (width_reg > rmf_pkg::MAX_WIDTH ? rmf_pkg::MAX_WIDTH : width_reg);
    h = height_reg == 0 ? 1 : height_reg;
    total = w * h;
    lag = rmf_pkg::RADIUS * w + rmf_pkg::RADIUS;
    pos = in_row * w + in_col;
    if (!frame_in) begin
      // early drain is dropped without touching anything
      if (drain) return;
      line_store[pos % DEPTH] = px;
    end
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (in_row * w + in_col >= total) frame_in = 1;
    if (pos < lag) return;
    k = 0;
    for (int dy = -rmf_pkg::RADIUS; dy <= rmf_pkg::RADIUS; dy++) begin
      for (int dx = -rmf_pkg::RADIUS; dx <= rmf_pkg::RADIUS; dx++) begin
        rr = clampi(int'(out_row) + dy, int'(h) - 1);
        cc = clampi(int'(out_col) + dx, int'(w) - 1);
        p = line_store[(rr * w + cc) % DEPTH];
        rv[k] = p[7:0];
        gv[k] = p[15:8];
        bv[k] = p[23:16];
        k++;
      end
    end
    res.red = median9(rv);
    res.green = median9(gv);
    res.blue = median9(bv);
    if (out_row * w + out_col + 1 >= total) begin
      res.last = 1'b1;
      restart();
    end else begin
      res.last = 1'b0;
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    medians_due.push_back(res);
  endtask

  always @(posedge clk) begin
    median_pix_t exp_pix;
    if (rst) begin
      width_reg = rmf_pkg::RESET_WIDTH;
      height_reg = rmf_pkg::RESET_HEIGHT;
      medians_due.delete();
      restart();
    end else begin
      if (m_tvalid && m_tready) begin
        if (medians_due.size() == 0) begin
          $error("result with nothing expected: data %h last %b", m_tdata, m_tlast);
          errors++;
        end else begin
          exp_pix = medians_due.pop_front();
          if (m_tdata[7:0] !== exp_pix.red) begin
            $error("out_red: expected %0d actual %0d", exp_pix.red, m_tdata[7:0]);
            errors++;
          end
          if (m_tdata[15:8] !== exp_pix.green) begin
            $error("out_green: expected %0d actual %0d", exp_pix.green, m_tdata[15:8]);
            errors++;
          end
          if (m_tdata[23:16] !== exp_pix.blue) begin
            $error("out_blue: expected %0d actual %0d", exp_pix.blue, m_tdata[23:16]);
            errors++;
          end
          if (m_tlast !== exp_pix.last) begin
            $error("frame_last: expected %0b actual %0b", exp_pix.last, m_tlast);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == rmf_pkg::CFG_FRAME_WIDTH) begin
          width_reg = cfg_data[rmf_pkg::FW_W-1:0];
          restart();
        end else if (cfg_index == rmf_pkg::CFG_FRAME_HEIGHT) begin
          height_reg = cfg_data[rmf_pkg::FH_W-1:0];
          restart();
        end
      end
      if (s_tvalid && s_tready) take_item(s_tuser, s_tdata);
    end
  end

  initial errors = 0;

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives whole frames of random and extreme pixels through the median filter
// over many frame sizes, with random gaps on both sides and a long output
// stall; the checker predicts and compares every result pixel.
// ----------------------------------------------------------------------------
module tb;

  logic                           clk = 0;
  logic                           rst = 1;
  logic                           s_tvalid = 0;
  logic                           s_tready;
  logic [23:0]                    s_tdata = '0;  // in_red, in_green, in_blue
  logic                           s_tuser = 0;   // mode
  logic                           m_tvalid;
  logic                           m_tready = 0;
  logic [23:0]                    m_tdata;       // out_red, out_green, out_blue
  logic                           m_tlast;
  logic                           cfg_valid = 0;
  logic                           cfg_ready;
  logic [rmf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [rmf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int pending, errors;
  bit s_took, cfg_took;
  bit calm, stall_req;
  int hold_left;
  int unsigned cur_w, cur_h, sent_items;

  always #5 clk = ~clk;

  rgb_median_window_filter_core i_dut (.*);

  median_stream_checker i_check (.*);

  always @(posedge clk) begin
    s_took <= s_tvalid && s_tready;
    cfg_took <= cfg_valid && cfg_ready;
  end

  // result side: random back pressure plus one long hold-off on request
  always @(negedge clk) begin
    if (stall_req && hold_left == 0) begin
      hold_left = 400;
      stall_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready = 0;
    end else begin
      m_tready = calm || rst ? 1 : ($urandom_range(99) >= 38);
    end
  end

  task automatic send(input logic drain, input logic [23:0] px);
    while (!calm && $urandom_range(99) < 38) begin
      s_tvalid = 0;
      @(negedge clk);
    end
    s_tvalid = 1;
    s_tuser = drain;
    s_tdata = px;
    do @(negedge clk); while (!s_took);
    sent_items++;
  endtask

  task automatic write_reg(input logic [rmf_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned val);
    s_tvalid = 0;
    wait (pending == 0);
    @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = val[rmf_pkg::CFG_DATA_W-1:0];
    do @(negedge clk); while (!cfg_took);
    cfg_valid = 0;
    if (idx == rmf_pkg::CFG_FRAME_WIDTH) begin
      cur_w = val[rmf_pkg::FW_W-1:0] == 0 ? 1 :
              (val[rmf_pkg::FW_W-1:0] > rmf_pkg::MAX_WIDTH ? rmf_pkg::MAX_WIDTH :
               val[rmf_pkg::FW_W-1:0]);
    end else begin
      cur_h = val[rmf_pkg::FH_W-1:0] == 0 ? 1 : val[rmf_pkg::FH_W-1:0];
    end
  endtask

  // style 0: random, 1: black/white extremes
  task automatic frame(input int style);
    logic [23:0] px;
    for (int unsigned i = 0; i < cur_w * cur_h; i++) begin
      // ignored drain before the frame is complete
      if ($urandom_range(19) == 0) send(1'b1, 24'($urandom));
      px = style == 1 ? ($urandom_range(1) ? 24'hffffff : 24'h000000) : 24'($urandom);
      send(1'b0, px);
    end
    for (int unsigned i = 0; i < rmf_pkg::RADIUS * cur_w + rmf_pkg::RADIUS; i++) begin
      // a late pixel counts as a drain item
      send($urandom_range(4) != 0, 24'($urandom));
    end
  endtask

  // start of a frame that a register write cuts short
  task automatic pixels_only(input int n);
    for (int i = 0; i < n; i++) send(1'b0, 24'($urandom));
  endtask

  initial begin
    cur_w = 640;
    cur_h = 480;
    sent_items = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;
    write_reg(rmf_pkg::CFG_FRAME_WIDTH, 3);
    write_reg(rmf_pkg::CFG_FRAME_HEIGHT, 3);
    frame(1);
    write_reg(rmf_pkg::CFG_FRAME_WIDTH, 0);
    write_reg(rmf_pkg::CFG_FRAME_HEIGHT, 0);
    frame(0);
    write_reg(rmf_pkg::CFG_FRAME_WIDTH, 2047);
    write_reg(rmf_pkg::CFG_FRAME_HEIGHT, 65535);
    pixels_only(20);
    write_reg(rmf_pkg::CFG_FRAME_WIDTH, 10);
    write_reg(rmf_pkg::CFG_FRAME_HEIGHT, 6);
    stall_req = 1;
    frame(0);
    while (sent_items < 1050) begin
      write_reg(rmf_pkg::CFG_FRAME_WIDTH,
                $urandom_range(9) == 0 ? $urandom_range(40, 1) : $urandom_range(12, 1));
      write_reg(rmf_pkg::CFG_FRAME_HEIGHT, $urandom_range(8, 1));
      calm = sent_items > 400 && sent_items < 650;
      frame(int'($urandom_range(5) == 0));
    end
    calm = 0;
    s_tvalid = 0;
    wait (pending == 0);
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("tb: errors");
    $finish;
  end

endmodule
